/* rtl/tsa_pkg.sv */
`timescale 1ns / 1ps

package tsa_pkg;

	// Array geometry.
	localparam int TOPICS  = 16;
	localparam int VOCAB   = 1024;
	localparam int CLASSES = 8;

	localparam int WORD_DEPTH  = TOPICS * VOCAB;
	localparam int CLASS_DEPTH = TOPICS * CLASSES;
	localparam int CLEAR_DEPTH = (WORD_DEPTH > CLASS_DEPTH) ? WORD_DEPTH : CLASS_DEPTH;

	localparam int TOPIC_AW = $clog2(TOPICS);
	localparam int WORD_AW  = $clog2(WORD_DEPTH);
	localparam int CLASS_AW = $clog2(CLASS_DEPTH);
	localparam int SWEEP_W  = $clog2(CLEAR_DEPTH);

	// Field widths of the item and result words.
	localparam int OP_W     = 2;
	localparam int TOPIC_W  = 4;
	localparam int WORDF_W  = 10;
	localparam int CLASSF_W = 3;
	localparam int RESP_W   = 16;
	localparam int COUNT_W  = 16;
	localparam int ETA_W    = 32;

	// Arithmetic widths.
	localparam int ACC_W     = 48;
	localparam int PROD_W    = RESP_W + COUNT_W;
	localparam int FRAC_W    = ACC_W + 1;
	localparam int FRAC_BITS = 16;
	localparam int QUOT_W    = FRAC_BITS + 1;
	localparam int ITER_W    = $clog2(FRAC_BITS + 1);

	typedef logic [ACC_W-1:0]    acc_t;
	typedef logic [PROD_W-1:0]   prod_t;
	typedef logic [FRAC_W-1:0]   frac_t;
	typedef logic [QUOT_W-1:0]   quot_t;
	typedef logic [TOPIC_AW-1:0] topic_addr_t;
	typedef logic [WORD_AW-1:0]  word_addr_t;
	typedef logic [CLASS_AW-1:0] class_addr_t;
	typedef logic [SWEEP_W-1:0]  sweep_t;

	localparam quot_t ONE_Q16 = quot_t'(1) << FRAC_BITS;

	typedef enum logic [OP_W-1:0] {
		OP_ACCUMULATE = 2'd0,
		OP_READ_WORD  = 2'd1,
		OP_READ_CLASS = 2'd2,
		OP_CLEAR      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC_WR,
		ST_RD_DATA,
		ST_DIV
	} state_t;

	// Write side of the statistics store.
	typedef struct packed {
		logic        word_we;
		logic        class_we;
		logic        row_we;
		logic        row_clr;
		word_addr_t  word_addr;
		class_addr_t class_addr;
		topic_addr_t topic;
		acc_t        word_data;
		acc_t        class_data;
		acc_t        word_row_data;
		acc_t        class_row_data;
	} store_wr_t;

	// Registered read data of the statistics store.
	typedef struct packed {
		acc_t word_entry;
		acc_t class_entry;
		acc_t word_row;
		acc_t class_row;
	} store_rd_t;

	typedef struct packed {
		logic  start;
		logic  empty;
		frac_t num;
		frac_t den;
	} div_req_t;

	typedef struct packed {
		logic  done;
		logic  empty;
		quot_t value;
	} div_rsp_t;

endpackage

/* rtl/tsa_stat_store.sv */
`timescale 1ns / 1ps

module tsa_stat_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsa_pkg::word_addr_t  rd_word_addr,
	input  tsa_pkg::class_addr_t rd_class_addr,
	input  tsa_pkg::topic_addr_t rd_topic,
	input  tsa_pkg::store_wr_t   wr,
	output tsa_pkg::store_rd_t   rd
);

	tsa_pkg::acc_t word_mem [tsa_pkg::WORD_DEPTH];
	tsa_pkg::acc_t class_mem [tsa_pkg::CLASS_DEPTH];
	tsa_pkg::acc_t word_row_q [tsa_pkg::TOPICS];
	tsa_pkg::acc_t class_row_q [tsa_pkg::TOPICS];

	tsa_pkg::acc_t word_entry_q;
	tsa_pkg::acc_t class_entry_q;
	tsa_pkg::acc_t word_row_rd_q;
	tsa_pkg::acc_t class_row_rd_q;

	always_ff @(posedge clk) begin
		if (wr.word_we) begin
			word_mem[wr.word_addr] <= wr.word_data;
		end
		word_entry_q <= word_mem[rd_word_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.class_we) begin
			class_mem[wr.class_addr] <= wr.class_data;
		end
		class_entry_q <= class_mem[rd_class_addr];
	end

	// Row sums are small enough to live in flops, so every topic's row sum clears at once on row_clr.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tsa_pkg::TOPICS; i++) begin
				word_row_q[i]  <= '0;
				class_row_q[i] <= '0;
			end
		end else if (wr.row_clr) begin
			for (int i = 0; i < tsa_pkg::TOPICS; i++) begin
				word_row_q[i]  <= '0;
				class_row_q[i] <= '0;
			end
		end else if (wr.row_we) begin
			word_row_q[wr.topic]  <= wr.word_row_data;
			class_row_q[wr.topic] <= wr.class_row_data;
		end
	end

	always_ff @(posedge clk) begin
		word_row_rd_q  <= word_row_q[rd_topic];
		class_row_rd_q <= class_row_q[rd_topic];
	end

	assign rd = {word_entry_q, class_entry_q, word_row_rd_q, class_row_rd_q};

endmodule

/* rtl/tsa_frac_div.sv */
`timescale 1ns / 1ps

module tsa_frac_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tsa_pkg::div_req_t  req,
	output tsa_pkg::div_rsp_t  rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [tsa_pkg::ITER_W-1:0]  iter_q;
	tsa_pkg::frac_t              rem_q;
	tsa_pkg::frac_t              den_q;
	tsa_pkg::quot_t              quot_q;
	logic                        empty_q;

	logic [tsa_pkg::FRAC_W:0]    rem_shift;
	logic [tsa_pkg::FRAC_W:0]    rem_diff;
	logic                        take;

	// One restoring step per cycle: shift, compare, subtract.
	always_comb begin
		rem_shift = {rem_q, 1'b0};
		rem_diff  = rem_shift - {1'b0, den_q};
		take      = rem_shift >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (req.start) begin
			if (req.empty || req.num >= req.den) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				iter_q <= tsa_pkg::ITER_W'(tsa_pkg::FRAC_BITS);
			end
		end else if (busy_q) begin
			iter_q <= iter_q - 1'b1;
			if (iter_q == tsa_pkg::ITER_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q   <= req.num;
			den_q   <= req.den;
			empty_q <= req.empty;
			if (req.empty) begin
				quot_q <= '0;
			end else if (req.num >= req.den) begin
				quot_q <= tsa_pkg::ONE_Q16;
			end else begin
				quot_q <= '0;
			end
		end else if (busy_q) begin
			rem_q  <= take ? rem_diff[tsa_pkg::FRAC_W-1:0] : rem_shift[tsa_pkg::FRAC_W-1:0];
			quot_q <= {quot_q[tsa_pkg::QUOT_W-2:0], take};
		end
	end

	assign rsp = {done_q, empty_q, quot_q};

endmodule

/* rtl/topic_statistics_accumulator.sv */
`timescale 1ns / 1ps

// Topic statistics accumulator. Each input word carries an op code: accumulate
// adds responsibility times word_count (Q0.16 units) with saturation at 2^48-1
// to a topic-word entry, that topic's topic-word row sum, a topic-class entry
// and that topic's topic-class row sum; a topic-word read or a topic-class read
// returns one result word holding the entry divided by its row sum in Q1.16,
// with eta_smoothing added to a class entry and CLASSES times eta_smoothing added
// to its row sum; clear zeroes every store and returns nothing. A zero row sum
// gives a value of 0 with row_empty set. The block handles one word at a time.
// An accumulate does the synchronous memory read, then the saturating add and
// write-back. A read does the smoothing add and divider start, the bit-serial
// divider steps, the result load (held while a finished result waits under
// stall), and a return to idle before the next word. When the row sum is zero
// or the entry is not below the row sum, the divider steps are skipped.
// After reset and after every clear the 16384-entry topic-word memory is swept
// to zero one entry per cycle, so the block stalls input until the sweep ends;
// configuration writes are taken during that time.
// The result is held in an output register, so the next word is accepted while
// a finished result still waits under stall.

module topic_statistics_accumulator (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_write_en,
	input  logic [tsa_pkg::ETA_W-1:0]        cfg_write_data,

	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [tsa_pkg::OP_W-1:0]         op,
	input  logic [tsa_pkg::TOPIC_W-1:0]      topic,
	input  logic [tsa_pkg::WORDF_W-1:0]      word,
	input  logic [tsa_pkg::CLASSF_W-1:0]     doc_class,
	input  logic [tsa_pkg::RESP_W-1:0]       responsibility,
	input  logic [tsa_pkg::COUNT_W-1:0]      word_count,

	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [tsa_pkg::QUOT_W-1:0]       normalized_value,
	output logic                             row_empty
);

	tsa_pkg::state_t      state_q;
	tsa_pkg::state_t      state_next;

	logic [tsa_pkg::ETA_W-1:0] eta_q;
	tsa_pkg::sweep_t      sweep_q;
	logic                 sweep_last;

	tsa_pkg::op_t         op_in;
	logic                 item_accept;
	tsa_pkg::word_addr_t  word_addr_c;
	tsa_pkg::class_addr_t class_addr_c;
	tsa_pkg::topic_addr_t topic_addr_c;

	tsa_pkg::op_t         op_q;
	tsa_pkg::word_addr_t  word_addr_q;
	tsa_pkg::class_addr_t class_addr_q;
	tsa_pkg::topic_addr_t topic_q;
	logic                 word_ok_q;
	logic                 class_ok_q;
	tsa_pkg::prod_t       prod_s1;

	tsa_pkg::store_wr_t   store_wr;
	tsa_pkg::store_rd_t   store_rd;
	tsa_pkg::div_req_t    div_req;
	tsa_pkg::div_rsp_t    div_rsp;

	tsa_pkg::frac_t       num_c;
	tsa_pkg::frac_t       den_c;
	logic                 out_load;

	logic                 result_valid_q;
	tsa_pkg::quot_t       value_q;
	logic                 empty_q;

	// Saturating 48-bit add of an accumulator entry and a product.
	function automatic tsa_pkg::acc_t sat_add(tsa_pkg::acc_t a, tsa_pkg::prod_t b);
		logic [tsa_pkg::ACC_W:0] s;
		s = {1'b0, a} + (tsa_pkg::ACC_W + 1)'(b);
		return s[tsa_pkg::ACC_W] ? '1 : s[tsa_pkg::ACC_W-1:0];
	endfunction

	assign op_in       = tsa_pkg::op_t'(op);
	assign item_accept = item_valid && !item_stall;
	assign sweep_last  = sweep_q == tsa_pkg::SWEEP_W'(tsa_pkg::CLEAR_DEPTH - 1);

	// Memory addresses come straight from the input word so the read lands
	// in the cycle after acceptance.
	assign topic_addr_c = tsa_pkg::TOPIC_AW'(topic);
	assign word_addr_c  = tsa_pkg::WORD_AW'(tsa_pkg::WORD_AW'(topic) *
		tsa_pkg::WORD_AW'(tsa_pkg::VOCAB) + tsa_pkg::WORD_AW'(word));
	assign class_addr_c = tsa_pkg::CLASS_AW'(tsa_pkg::CLASS_AW'(topic) *
		tsa_pkg::CLASS_AW'(tsa_pkg::CLASSES) + tsa_pkg::CLASS_AW'(doc_class));

	tsa_stat_store u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_word_addr  (word_addr_c),
		.rd_class_addr (class_addr_c),
		.rd_topic      (topic_addr_c),
		.wr            (store_wr),
		.rd            (store_rd)
	);

	tsa_frac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Numerator and denominator of a read, with smoothing on the class side.
	always_comb begin
		num_c = '0;
		den_c = '0;
		if (op_q == tsa_pkg::OP_READ_CLASS) begin
			if (class_ok_q) begin
				num_c = tsa_pkg::FRAC_W'(store_rd.class_entry) + tsa_pkg::FRAC_W'(eta_q);
				den_c = tsa_pkg::FRAC_W'(store_rd.class_row) +
					tsa_pkg::FRAC_W'(tsa_pkg::FRAC_W'(eta_q) *
					tsa_pkg::FRAC_W'(tsa_pkg::CLASSES));
			end
		end else begin
			if (word_ok_q) begin
				num_c = tsa_pkg::FRAC_W'(store_rd.word_entry);
				den_c = tsa_pkg::FRAC_W'(store_rd.word_row);
			end
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			tsa_pkg::ST_CLEAR: begin
				if (sweep_last) begin
					state_next = tsa_pkg::ST_IDLE;
				end
			end
			tsa_pkg::ST_IDLE: begin
				if (item_accept) begin
					case (op_in)
						tsa_pkg::OP_ACCUMULATE: state_next = tsa_pkg::ST_ACC_WR;
						tsa_pkg::OP_READ_WORD:  state_next = tsa_pkg::ST_RD_DATA;
						tsa_pkg::OP_READ_CLASS: state_next = tsa_pkg::ST_RD_DATA;
						tsa_pkg::OP_CLEAR:      state_next = tsa_pkg::ST_CLEAR;
						default:                state_next = tsa_pkg::ST_IDLE;
					endcase
				end
			end
			tsa_pkg::ST_ACC_WR: begin
				state_next = tsa_pkg::ST_IDLE;
			end
			tsa_pkg::ST_RD_DATA: begin
				state_next = tsa_pkg::ST_DIV;
			end
			tsa_pkg::ST_DIV: begin
				if (out_load) begin
					state_next = tsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = tsa_pkg::ST_IDLE;
			end
		endcase
	end

	// State outputs: input stall, store writes, divider start, result load.
	always_comb begin
		item_stall              = 1'b1;
		store_wr                = '0;
		store_wr.topic          = topic_q;
		store_wr.word_addr      = word_addr_q;
		store_wr.class_addr     = class_addr_q;
		div_req                 = '0;
		div_req.num             = num_c;
		div_req.den             = den_c;
		out_load                = 1'b0;
		case (state_q)
			tsa_pkg::ST_CLEAR: begin
				store_wr.row_clr    = 1'b1;
				store_wr.word_we    = sweep_q < tsa_pkg::WORD_DEPTH;
				store_wr.class_we   = sweep_q < tsa_pkg::CLASS_DEPTH;
				store_wr.word_addr  = sweep_q[tsa_pkg::WORD_AW-1:0];
				store_wr.class_addr = sweep_q[tsa_pkg::CLASS_AW-1:0];
			end
			tsa_pkg::ST_IDLE: begin
				item_stall = 1'b0;
			end
			tsa_pkg::ST_ACC_WR: begin
				store_wr.word_we        = word_ok_q && class_ok_q;
				store_wr.class_we       = word_ok_q && class_ok_q;
				store_wr.row_we         = word_ok_q && class_ok_q;
				store_wr.word_data      = sat_add(store_rd.word_entry, prod_s1);
				store_wr.class_data     = sat_add(store_rd.class_entry, prod_s1);
				store_wr.word_row_data  = sat_add(store_rd.word_row, prod_s1);
				store_wr.class_row_data = sat_add(store_rd.class_row, prod_s1);
			end
			tsa_pkg::ST_RD_DATA: begin
				div_req.start = 1'b1;
				div_req.empty = den_c == '0;
			end
			tsa_pkg::ST_DIV: begin
				out_load = div_rsp.done && (!result_valid_q || !result_stall);
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsa_pkg::ST_CLEAR;
			sweep_q <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == tsa_pkg::ST_CLEAR) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
			end else if (item_accept && op_in == tsa_pkg::OP_CLEAR) begin
				sweep_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_q <= '0;
		end else if (cfg_write_en) begin
			eta_q <= cfg_write_data;
		end
	end

	// Fields of the accepted word; the product is formed alongside the read.
	always_ff @(posedge clk) begin
		if (item_accept) begin
			op_q         <= op_in;
			topic_q      <= topic_addr_c;
			word_addr_q  <= word_addr_c;
			class_addr_q <= class_addr_c;
			word_ok_q    <= topic < tsa_pkg::TOPICS && word < tsa_pkg::VOCAB;
			class_ok_q   <= topic < tsa_pkg::TOPICS && doc_class < tsa_pkg::CLASSES;
			prod_s1      <= tsa_pkg::PROD_W'(responsibility) * tsa_pkg::PROD_W'(word_count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q <= div_rsp.value;
			empty_q <= div_rsp.empty;
		end
	end

	assign result_valid     = result_valid_q;
	assign normalized_value = value_q;
	assign row_empty        = empty_q;

	// A new result only ever comes out of the divide state.
	a_result_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == tsa_pkg::ST_DIV)
		else $error("result appeared without a finished division");

	// An accepted accumulate goes straight to its write-back cycle.
	a_acc_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		item_accept && op_in == tsa_pkg::OP_ACCUMULATE |=> state_q == tsa_pkg::ST_ACC_WR)
		else $error("accumulate did not reach write-back");

	// The memories are never written while the block waits for input.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tsa_pkg::ST_IDLE |-> !store_wr.word_we && !store_wr.class_we
			&& !store_wr.row_we)
		else $error("store written while idle");

	// A division start that needs the bit-serial steps always clears the previous completion first.
	a_div_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start && !div_req.empty && num_c < den_c |=> !div_rsp.done)
		else $error("divider reported done right after a full start");

endmodule
